@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue cells, the top
// level and its checker.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int KEY_BITS   = 16;
  localparam int ID_BITS    = 8;
  localparam int COUNT_BITS = 5;

  // request operations
  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP_FRONT = 2'd1,
    OP_POP_BACK  = 2'd2,
    OP_REMOVE    = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [ID_BITS-1:0]  id_t;

  // one input item
  typedef struct packed {
    op_t  op;
    key_t entry_key;
    id_t  entry_id;
  } in_item_t;

  // one result item
  typedef struct packed {
    status_t               status;
    key_t                  front_key;
    id_t                   front_id;
    key_t                  back_key;
    id_t                   back_id;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  is_empty;
  } out_item_t;

  // contents of one cell
  typedef struct packed {
    key_t key;
    id_t  id;
  } slot_t;

  // command broadcast to every cell
  typedef struct packed {
    logic en;
    op_t  op;
    key_t key;
    id_t  id;
  } cmd_t;

endpackage

@@ rtl/core/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. Holds a key and an id and picks its next value
// from itself, the new entry or one of its two neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic           clk,
  input  spq_pkg::cmd_t  cmd,
  input  logic           valid,
  input  spq_pkg::slot_t left_slot,
  input  logic           left_le,
  input  spq_pkg::slot_t right_slot,
  input  logic           found_in,
  output spq_pkg::slot_t slot_q,
  output logic           le,
  output logic           found_out
);

  spq_pkg::slot_t slot_r;
  spq_pkg::slot_t slot_nxt;
  logic           match;

  // compare against the broadcast key and id
  assign le        = valid && (slot_r.key <= cmd.key);
  assign match     = valid && (slot_r.id == cmd.id);
  assign found_out = found_in | match;
  assign slot_q    = slot_r;

  // next value selection
  always_comb begin
    slot_nxt = slot_r;
    case (cmd.op)
      spq_pkg::OP_PUSH: begin
        if (!le) begin
          if (left_le) begin
            slot_nxt.key = cmd.key;
            slot_nxt.id  = cmd.id;
          end else begin
            slot_nxt = left_slot;
          end
        end
      end
      spq_pkg::OP_POP_FRONT: slot_nxt = right_slot;
      spq_pkg::OP_POP_BACK:  slot_nxt = slot_r;
      spq_pkg::OP_REMOVE: begin
        if (found_out) slot_nxt = right_slot;
      end
      default: slot_nxt = slot_r;
    endcase
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (cmd.en) slot_r <= slot_nxt;
  end

endmodule

@@ rtl/core/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Stable sorted queue of up to DEPTH key/id entries built as a row of cells.
// ----------------------------------------------------------------------------
// The queue takes one item per clock cycle and returns its result in the cycle
// after acceptance from an output register; in_stall rises only while a
// result waits and out_stall is high. Every cell updates in the same cycle:
// a push opens a gap after the last entry with a key not above the new one,
// pop front and remove by id close a gap by shifting from the right, pop back
// only lowers the count. The clock period is set by the id-match carry that
// ripples through the row of cells for remove by id. Entries beyond the count
// are never shown, so the cells need no clearing after reset.
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  spq_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output spq_pkg::out_item_t  out_item
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CNT_W = spq_pkg::COUNT_BITS;

  logic             in_accept;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             out_valid_r;
  spq_pkg::status_t status_r;
  spq_pkg::status_t status_nxt;
  spq_pkg::cmd_t    cmd;
  logic             is_full;
  logic             is_empty;

  spq_pkg::slot_t   cell_q   [DEPTH];
  logic             cell_le  [DEPTH];
  logic             found_c  [DEPTH+1];

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);

  // status of the item at the head of the input channel
  always_comb begin
    status_nxt = spq_pkg::ST_OK;
    count_nxt  = count_r;
    case (in_item.op)
      spq_pkg::OP_PUSH: begin
        if (is_full) status_nxt = spq_pkg::ST_FULL;
        else count_nxt = count_r + CW'(1);
      end
      spq_pkg::OP_POP_FRONT, spq_pkg::OP_POP_BACK: begin
        if (is_empty) status_nxt = spq_pkg::ST_EMPTY;
        else count_nxt = count_r - CW'(1);
      end
      spq_pkg::OP_REMOVE: begin
        if (!found_c[DEPTH]) status_nxt = spq_pkg::ST_EMPTY;
        else count_nxt = count_r - CW'(1);
      end
      default: status_nxt = spq_pkg::ST_OK;
    endcase
  end

  // broadcast command, only items that succeed touch the cells
  always_comb begin
    cmd.en  = in_accept && (status_nxt == spq_pkg::ST_OK);
    cmd.op  = in_item.op;
    cmd.key = in_item.entry_key;
    cmd.id  = in_item.entry_id;
  end

  assign found_c[0] = 1'b0;

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::slot_t left_slot;
    spq_pkg::slot_t right_slot;
    logic           left_le;

    if (i == 0) begin : g_first
      assign left_slot = cell_q[0];
      assign left_le   = 1'b1;
    end else begin : g_mid
      assign left_slot = cell_q[i-1];
      assign left_le   = cell_le[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_slot = cell_q[i];
    end else begin : g_inner
      assign right_slot = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid      (CW'(i) < count_r),
      .left_slot  (left_slot),
      .left_le    (left_le),
      .right_slot (right_slot),
      .found_in   (found_c[i]),
      .slot_q     (cell_q[i]),
      .le         (cell_le[i]),
      .found_out  (found_c[i+1])
    );
  end

  // count, result valid and status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= spq_pkg::ST_OK;
    end else begin
      if (in_accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        status_r    <= status_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result fields from the settled cell row
  always_comb begin
    out_item             = '0;
    out_item.status      = status_r;
    out_item.entry_count = CNT_W'(count_r);
    out_item.is_empty    = is_empty;
    if (!is_empty) begin
      out_item.front_key = cell_q[0].key;
      out_item.front_id  = cell_q[0].id;
      for (int i = 0; i < DEPTH; i++) begin
        if (CW'(i) == count_r - CW'(1)) begin
          out_item.back_key = cell_q[i].key;
          out_item.back_id  = cell_q[i].id;
        end
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input spq_pkg::out_item_t out_item
);

  // every accepted item shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item produced no result");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.is_empty == (out_item.entry_count == '0)))
    else $error("empty flag and count disagree");

  // front never sorts above back
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.is_empty) |-> (out_item.front_key <= out_item.back_key))
    else $error("front key above back key");

  // count stays within depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_item.entry_count) <= DEPTH))
    else $error("count above depth");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
